@@ rtl/womh_pkg.sv @@
package womh_pkg;

    localparam int unsigned VAL_W = 32;
    localparam int unsigned CNT_W = 11;
    localparam int unsigned WIN_W = 31;
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    // Register decode uses the word index taken from paddr[2].
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef struct packed {
        logic                    begin_req;
        logic signed [VAL_W-1:0] seg_start;
        logic signed [VAL_W-1:0] seg_end;
    } womh_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] live_count;
        logic [CNT_W-1:0] best_count;
        logic             overflow;
    } womh_result_t;

endpackage

@@ rtl/womh_ram.sv @@
module womh_ram
    import womh_pkg::*;
#(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [VAL_W-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [VAL_W-1:0] rdata_a,
    output logic [VAL_W-1:0] rdata_b
);

    // Contents are undefined until written; the controller only reads live entries.
    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_a_reg;
    logic [VAL_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ rtl/womh_ctrl.sv @@
module womh_ctrl
    import womh_pkg::*;
#(
    parameter int unsigned HEAP_DEPTH = 1024,
    parameter int unsigned AW         = 10,
    parameter int unsigned FW         = 11
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WIN_W-1:0]  window_length,
    input  logic              start,
    input  womh_cmd_t         cmd,
    output logic              busy,
    output logic              done,
    output womh_result_t      result,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output logic [VAL_W-1:0]  mem_wdata,
    output logic [AW-1:0]     mem_raddr_a,
    output logic [AW-1:0]     mem_raddr_b,
    input  logic [VAL_W-1:0]  mem_rdata_a,
    input  logic [VAL_W-1:0]  mem_rdata_b
);

    localparam int unsigned IW = AW + 2;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_POP_RD   = 8'b0000_0010,
        ST_POP_CHK  = 8'b0000_0100,
        ST_POP_LAST = 8'b0000_1000,
        ST_SIFT_DN  = 8'b0001_0000,
        ST_PUSH_UP  = 8'b0010_0000,
        ST_PUSH_FIN = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [FW-1:0]           fill_reg, fill_next;
    logic [FW-1:0]           best_reg, best_next;
    logic [AW-1:0]           cur_reg, cur_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic signed [VAL_W-1:0] start_reg, start_next;
    logic signed [VAL_W-1:0] end_reg, end_next;
    logic                    ovf_reg, ovf_next;
    logic                    done_reg, done_next;
    womh_result_t            result_reg, result_next;

    logic [FW-1:0]           fill_base;
    logic [FW-1:0]           best_base;
    logic [FW-1:0]           best_max;
    logic signed [VAL_W:0]   span;
    logic signed [VAL_W:0]   age;
    logic signed [VAL_W:0]   win_ext;
    logic [IW-1:0]           left_idx;
    logic [IW-1:0]           right_idx;
    logic [IW-1:0]           fill_ext;
    logic                    take_l;
    logic                    take_r;
    logic signed [VAL_W-1:0] min_lv;
    logic [AW-1:0]           child_sel;
    logic [IW-1:0]           next_left;
    logic [AW-1:0]           parent_idx;
    logic [AW-1:0]           grand_idx;
    logic [FW+CNT_W-1:0]     live_wide;
    logic [FW+CNT_W-1:0]     best_wide;

    assign fill_base = cmd.begin_req ? '0 : fill_reg;
    assign best_base = cmd.begin_req ? '0 : best_reg;
    assign best_max  = (fill_reg > best_reg) ? fill_reg : best_reg;
    assign win_ext   = $signed({2'b00, window_length});
    assign span      = {cmd.seg_end[VAL_W-1], cmd.seg_end}
                     - {cmd.seg_start[VAL_W-1], cmd.seg_start};
    assign age       = {end_reg[VAL_W-1], end_reg} - {mem_rdata_a[VAL_W-1], mem_rdata_a};

    // Sift-down: pick the smaller live child against the element being placed.
    assign left_idx  = {1'b0, cur_reg, 1'b1};
    assign right_idx = left_idx + IW'(1);
    assign fill_ext  = IW'(fill_reg);
    assign take_l    = (left_idx < fill_ext) && ($signed(mem_rdata_a) < val_reg);
    assign min_lv    = take_l ? $signed(mem_rdata_a) : val_reg;
    assign take_r    = (right_idx < fill_ext) && ($signed(mem_rdata_b) < min_lv);
    assign child_sel = take_r ? right_idx[AW-1:0] : left_idx[AW-1:0];
    assign next_left = {1'b0, child_sel, 1'b1};

    // Sift-up: parent of the current slot and of that parent.
    assign parent_idx = (cur_reg - AW'(1)) >> 1;
    assign grand_idx  = (parent_idx - AW'(1)) >> 1;

    assign live_wide = {{CNT_W{1'b0}}, fill_reg};
    assign best_wide = {{CNT_W{1'b0}}, best_max};

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        best_next   = best_reg;
        cur_next    = cur_reg;
        val_next    = val_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        ovf_next    = ovf_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        mem_we      = 1'b0;
        mem_waddr   = cur_reg;
        mem_wdata   = val_reg;
        mem_raddr_a = '0;
        mem_raddr_b = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    fill_next  = fill_base;
                    best_next  = best_base;
                    start_next = cmd.seg_start;
                    end_next   = cmd.seg_end;
                    ovf_next   = 1'b0;
                    if (span > win_ext)
                    begin
                        // Too long for the window: report the counts, heap untouched.
                        done_next              = 1'b1;
                        result_next.live_count = CNT_W'({{CNT_W{1'b0}}, fill_base});
                        result_next.best_count = CNT_W'({{CNT_W{1'b0}}, best_base});
                        result_next.overflow   = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_POP_RD;
                    end
                end
            end
            ST_POP_RD:
            begin
                mem_raddr_a = '0;
                state_next  = ST_POP_CHK;
            end
            ST_POP_CHK:
            begin
                if ((fill_reg != '0) && (age > win_ext))
                begin
                    fill_next   = fill_reg - FW'(1);
                    mem_raddr_a = AW'(fill_reg - FW'(1));
                    state_next  = ST_POP_LAST;
                end
                else if (fill_reg >= FW'(HEAP_DEPTH))
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cur_next    = AW'(fill_reg);
                    val_next    = start_reg;
                    fill_next   = fill_reg + FW'(1);
                    mem_raddr_a = AW'((fill_reg - FW'(1)) >> 1);
                    state_next  = (fill_reg == '0) ? ST_PUSH_FIN : ST_PUSH_UP;
                end
            end
            ST_POP_LAST:
            begin
                val_next    = $signed(mem_rdata_a);
                cur_next    = '0;
                mem_raddr_a = AW'(1);
                mem_raddr_b = AW'(2);
                state_next  = (fill_reg == '0) ? ST_POP_RD : ST_SIFT_DN;
            end
            ST_SIFT_DN:
            begin
                mem_we = 1'b1;
                if (take_l || take_r)
                begin
                    mem_wdata   = take_r ? mem_rdata_b : mem_rdata_a;
                    cur_next    = child_sel;
                    mem_raddr_a = next_left[AW-1:0];
                    mem_raddr_b = AW'(next_left + IW'(1));
                end
                else
                begin
                    state_next = ST_POP_RD;
                end
            end
            ST_PUSH_UP:
            begin
                mem_we = 1'b1;
                if ($signed(mem_rdata_a) > val_reg)
                begin
                    mem_wdata   = mem_rdata_a;
                    cur_next    = parent_idx;
                    mem_raddr_a = grand_idx;
                    state_next  = (parent_idx == '0) ? ST_PUSH_FIN : ST_PUSH_UP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PUSH_FIN:
            begin
                mem_we     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                best_next              = best_max;
                done_next              = 1'b1;
                result_next.live_count = live_wide[CNT_W-1:0];
                result_next.best_count = best_wide[CNT_W-1:0];
                result_next.overflow   = ovf_reg;
                state_next             = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            best_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            best_reg  <= best_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        val_reg    <= val_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        ovf_reg    <= ovf_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // A result is only presented once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == ST_IDLE)
        else $error("result strobe while sequencer busy");

    // The heap never holds more starts than it has slots.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(HEAP_DEPTH))
        else $error("heap fill beyond depth");

    // A refused push only happens with a full heap.
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.overflow) |-> fill_reg == FW'(HEAP_DEPTH))
        else $error("overflow reported with room in heap");

    // The heap memory is only written while an item is in progress.
    a_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg != ST_IDLE)
        else $error("heap write while idle");

    // At rest the best count always covers the live count.
    a_best_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> best_reg >= fill_reg)
        else $error("best count below live count");

endmodule

@@ rtl/window_overlap_min_heap_unit.sv @@
// Channel      Handshake           Payload                  Notes
// command      start / busy        cmd   (womh_cmd_t)       taken when start && !busy
// result       done (1 cycle)      result (womh_result_t)   one per command, no stall
// config       APB psel/penable    paddr, pwdata, prdata    pready tied high
//
// A segment longer than the window is answered in the cycle after it is
// taken and the block stays free. Otherwise the strobe comes after the pops of
// expired starts and the push with its sift-up, or after the pops alone when a
// full heap refuses the push.
// A sift-down cycle examines one tree level; none runs when a pop empties the heap.
// The sift loops run through the single heap memory, one tree level per cycle.
// Reset clears the counts, the window length and the sequencer; heap contents are
// not cleared since only entries below the fill count are ever read.
// The result is a one-cycle strobe; the receiver has no way to stall it.
module window_overlap_min_heap_unit
    import womh_pkg::*;
#(
    parameter int unsigned HEAP_DEPTH = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Command transaction.
    input  logic              start,
    input  womh_cmd_t         cmd,
    output logic              busy,
    // Result transaction.
    output logic              done,
    output womh_result_t      result,
    // Register port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // Heap addresses cover the depth; the fill count must also hold the depth itself.
    localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int unsigned FW = $clog2(HEAP_DEPTH + 1);

    logic [WIN_W-1:0] window_length_reg;
    logic             reg_write;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr_a;
    logic [AW-1:0]    mem_raddr_b;
    logic [VAL_W-1:0] mem_rdata_a;
    logic [VAL_W-1:0] mem_rdata_b;

    // The register write completes in the access phase; pready is always high,
    // so no access is held in wait states.
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= '0;
        end
        else if (reg_write && (paddr[2] == REG_WINDOW_LENGTH))
        begin
            window_length_reg <= pwdata[WIN_W-1:0];
        end
    end

    // Reads of an address beyond the register list return zero.
    assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? {1'b0, window_length_reg} : '0;

    // The sequencer runs pops and the push through the heap memory.
    womh_ctrl #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .AW         (AW),
        .FW         (FW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (window_length_reg),
        .start         (start),
        .cmd           (cmd),
        .busy          (busy),
        .done          (done),
        .result        (result),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr_a   (mem_raddr_a),
        .mem_raddr_b   (mem_raddr_b),
        .mem_rdata_a   (mem_rdata_a),
        .mem_rdata_b   (mem_rdata_b)
    );

    // Two read ports let sift-down fetch both children of a node at once.
    womh_ram #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

endmodule

@@ verif/window_overlap_min_heap_unit_tb.sv @@
`timescale 1ns / 1ps

// Testbench for the sweep-line window counter built on a min-heap of segment starts.
//
// Command transactions go in on start/busy, and every command causes exactly one
// result transaction on the done strobe. The receiver cannot stall that strobe.
// A mirror of the heap, the fill count, the best count and the window register
// lives in this file. Every accepted command is run through that mirror at the
// edge where it is taken, and the outcome is queued. Each done strobe pops the
// oldest queued outcome and compares it field by field.
//
// The window length register is written through the APB port only while the
// block is idle. Each write is read back once.
module window_overlap_min_heap_unit_tb;

    import womh_pkg::*;

    localparam int          HEAP_DEPTH   = 1024;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          PHASE_ITEMS  = 330;
    localparam int          FILL_ITEMS   = HEAP_DEPTH + 16;

    localparam logic signed [VAL_W-1:0] S32_MIN   = 32'h8000_0000;
    localparam logic signed [VAL_W-1:0] S32_MAX   = 32'h7FFF_FFFF;
    localparam longint                  S32_MIN_L = -64'sd2147483648;
    localparam longint                  S32_MAX_L = 64'sd2147483647;
    localparam logic [WIN_W-1:0]        WIN_MAX   = 31'h7FFF_FFFF;
    localparam logic [APB_AW-1:0]       WIN_ADDR  = {REG_WINDOW_LENGTH, 2'b00};

    // One row of the directed table. The window is written before the row when
    // wr is set. When chk is set, the typed-in counts are the expectation.
    // Otherwise the mirror supplies the expectation.
    typedef struct packed {
        logic                    wr;
        logic [WIN_W-1:0]        win;
        logic                    bgn;
        logic signed [VAL_W-1:0] s;
        logic signed [VAL_W-1:0] e;
        logic                    chk;
        logic [CNT_W-1:0]        live;
        logic [CNT_W-1:0]        best;
        logic                    ovf;
    } stim_row_t;

    localparam int STIM_ROWS = 19;

    // Rows 0 to 7 run with the window at its reset value of zero.
    localparam stim_row_t STIM_TAB [STIM_ROWS] = '{
        // Zero span fits a zero window.
        '{1'b0, '0, 1'b0, 32'sd5, 32'sd5, 1'b1, 11'd1, 11'd1, 1'b0},
        // Span one is too long, so the heap stays as it is.
        '{1'b0, '0, 1'b0, 32'sd4, 32'sd5, 1'b1, 11'd1, 11'd1, 1'b0},
        // The old start falls out of the window, and the new one goes in.
        '{1'b0, '0, 1'b0, 32'sd6, 32'sd6, 1'b1, 11'd1, 11'd1, 1'b0},
        '{1'b0, '0, 1'b0, 32'sd6, 32'sd6, 1'b1, 11'd2, 11'd2, 1'b0},
        // A reversed segment has a negative span and is kept.
        '{1'b0, '0, 1'b0, 32'sd100, 32'sd6, 1'b1, 11'd3, 11'd3, 1'b0},
        // Begin clears the counts. The widest span is skipped.
        '{1'b0, '0, 1'b1, S32_MIN, S32_MAX, 1'b1, 11'd0, 11'd0, 1'b0},
        // The most negative span: it must not wrap into a skip.
        '{1'b0, '0, 1'b0, S32_MAX, S32_MIN, 1'b1, 11'd1, 11'd1, 1'b0},
        '{1'b0, '0, 1'b0, S32_MIN, S32_MIN, 1'b1, 11'd2, 11'd2, 1'b0},
        // Window at its maximum: a span of 2^32-1 and one of 2^31 are both skipped.
        '{1'b1, WIN_MAX, 1'b1, S32_MIN, S32_MAX, 1'b1, 11'd0, 11'd0, 1'b0},
        '{1'b0, WIN_MAX, 1'b0, -32'sd1, S32_MAX, 1'b1, 11'd0, 11'd0, 1'b0},
        // A span exactly equal to the window is kept.
        '{1'b0, WIN_MAX, 1'b0, 32'sd0, S32_MAX, 1'b1, 11'd1, 11'd1, 1'b0},
        '{1'b0, WIN_MAX, 1'b0, S32_MIN, -32'sd1, 1'b1, 11'd2, 11'd2, 1'b0},
        // The start distance 2^32-1 pops. The distance equal to the window stays.
        '{1'b0, WIN_MAX, 1'b0, S32_MAX, S32_MAX, 1'b1, 11'd2, 11'd2, 1'b0},
        // Small window: this sequence pops several entries in one item.
        '{1'b1, 31'd10, 1'b1, 32'sd0, 32'sd0, 1'b0, '0, '0, 1'b0},
        '{1'b0, 31'd10, 1'b0, 32'sd3, 32'sd5, 1'b0, '0, '0, 1'b0},
        '{1'b0, 31'd10, 1'b0, 32'sd1, 32'sd12, 1'b0, '0, '0, 1'b0},
        '{1'b0, 31'd10, 1'b0, 32'sd20, 32'sd30, 1'b0, '0, '0, 1'b0},
        '{1'b0, 31'd10, 1'b0, 32'sd19, 32'sd30, 1'b0, '0, '0, 1'b0},
        // Begin in the middle of a populated heap.
        '{1'b0, 31'd10, 1'b1, 32'sd30, 32'sd30, 1'b0, '0, '0, 1'b0}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    womh_cmd_t           cmd;
    logic                busy;
    logic                done;
    womh_result_t        result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // Mirror of the block's state.
    int                  mirror_starts [HEAP_DEPTH];
    int unsigned         mirror_fill;
    int unsigned         mirror_best;
    logic [WIN_W-1:0]    mirror_window;

    // Counts expected from accepted commands, oldest first.
    womh_result_t        pending_counts [$];
    womh_result_t        want;

    int                  idle_pct;
    int                  mismatch_count;
    int                  n_items;
    int                  n_results;
    int                  n_refused;
    int                  n_win_writes;
    int                  cycle_count;

    window_overlap_min_heap_unit #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 clk = ~clk;

    // This is the hard stop in case the block hangs or loses a result.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still pending.",
                     cycle_count, pending_counts.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic note_mismatch(input string msg);
        if (mismatch_count < 10)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Removes the earliest start. The last leaf moves to the root and sifts down.
    function automatic void mirror_pop_earliest();
        int unsigned pos;
        int unsigned lt;
        int unsigned rt;
        int unsigned least;
        int          held;
        mirror_fill--;
        mirror_starts[0] = mirror_starts[mirror_fill];
        pos = 0;
        while (1'b1)
        begin
            lt = 2 * pos + 1;
            rt = lt + 1;
            least = pos;
            if (lt < mirror_fill && mirror_starts[lt] < mirror_starts[least])
                least = lt;
            if (rt < mirror_fill && mirror_starts[rt] < mirror_starts[least])
                least = rt;
            if (least == pos)
                break;
            held = mirror_starts[pos];
            mirror_starts[pos] = mirror_starts[least];
            mirror_starts[least] = held;
            pos = least;
        end
    endfunction

    function automatic void mirror_push_start(input int v);
        int unsigned pos;
        int unsigned up;
        int          held;
        pos = mirror_fill;
        mirror_starts[pos] = v;
        mirror_fill++;
        while (pos > 0)
        begin
            up = (pos - 1) / 2;
            if (mirror_starts[up] <= mirror_starts[pos])
                break;
            held = mirror_starts[up];
            mirror_starts[up] = mirror_starts[pos];
            mirror_starts[pos] = held;
            pos = up;
        end
    endfunction

    // The sweep step for one segment. Spans use 64-bit math so that they never wrap.
    function automatic womh_result_t predict_counts(input womh_cmd_t c);
        longint       s_v;
        longint       e_v;
        longint       w_v;
        womh_result_t r;
        s_v = longint'($signed(c.seg_start));
        e_v = longint'($signed(c.seg_end));
        w_v = longint'({1'b0, mirror_window});
        r.overflow = 1'b0;
        if (c.begin_req)
        begin
            mirror_fill = 0;
            mirror_best = 0;
        end
        if (e_v - s_v <= w_v)
        begin
            while (mirror_fill > 0 && e_v - longint'(mirror_starts[0]) > w_v)
                mirror_pop_earliest();
            if (mirror_fill >= HEAP_DEPTH)
                r.overflow = 1'b1;
            else
                mirror_push_start(int'($signed(c.seg_start)));
            if (mirror_fill > mirror_best)
                mirror_best = mirror_fill;
        end
        r.live_count = CNT_W'(mirror_fill);
        r.best_count = CNT_W'(mirror_best);
        return r;
    endfunction

    // Sends one command transaction. The call starts and ends at a falling edge.
    // start is left high, so that back-to-back commands need no idle gap between them.
    task automatic send_cmd(input womh_cmd_t c, input logic typed,
                            input womh_result_t typed_res);
        womh_result_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = predict_counts(c);
        pending_counts.push_back(typed ? typed_res : predicted);
        n_items++;
        @(negedge clk);
    endtask

    // Writes the window length once every result is in and the block is free,
    // then reads the register back.
    task automatic write_window(input logic [WIN_W-1:0] v);
        start <= 1'b0;
        while (pending_counts.size() != 0 || busy)
            @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WIN_ADDR;
        pwdata  <= {1'b0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        mirror_window = v;
        n_win_writes++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {1'b0, v})
            note_mismatch($sformatf("window readback %h, wrote %h", prdata, v));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // A run of segments sorted by end point, with random content. Most spans fit
    // the window, some hit it exactly, some just miss it, and some are reversed.
    // A share of the items is unsorted noise.
    task automatic drive_sequence(input int len);
        longint      e_v;
        longint      s_v;
        longint      span;
        longint      w_v;
        longint      step_hi;
        int unsigned pick;
        logic        open_with_begin;
        womh_cmd_t   c;
        w_v = longint'({1'b0, mirror_window});
        step_hi = (w_v < 16) ? 16 : w_v / 3;
        e_v = longint'($signed($urandom));
        open_with_begin = ($urandom_range(0, 3) != 0);
        for (int k = 0; k < len; k++)
        begin
            if (k > 0)
                e_v += longint'($urandom_range(0, 32'(step_hi)));
            if (e_v > S32_MAX_L)
                e_v = S32_MAX_L;
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                c.begin_req = ($urandom_range(0, 7) == 0);
                c.seg_start = $urandom;
                c.seg_end   = $urandom;
            end
            else
            begin
                if (pick < 65)
                    span = longint'($urandom_range(0, 32'(w_v)));
                else if (pick < 75)
                    span = w_v;
                else if (pick < 85)
                    span = w_v + 1 + longint'($urandom_range(0, 15));
                else
                    span = -longint'($urandom_range(1, 1000));
                s_v = e_v - span;
                if (s_v < S32_MIN_L)
                    s_v = S32_MIN_L;
                if (s_v > S32_MAX_L)
                    s_v = S32_MAX_L;
                c.begin_req = (k == 0) && open_with_begin;
                c.seg_start = s_v[VAL_W-1:0];
                c.seg_end   = e_v[VAL_W-1:0];
            end
            send_cmd(c, 1'b0, '0);
        end
    endtask

    // One idle setting: window changes between sequences, with zero and the
    // maximum each picked one time in ten.
    task automatic run_phase(input int pct, input int n);
        int          sent;
        int unsigned pick;
        logic [WIN_W-1:0] w;
        idle_pct = pct;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                w = '0;
            else if (pick == 1)
                w = WIN_MAX;
            else if (pick < 6)
                w = WIN_W'($urandom_range(0, 64));
            else if (pick < 8)
                w = WIN_W'($urandom_range(0, 100000));
            else
                w = WIN_W'($urandom);
            write_window(w);
            pick = $urandom_range(5, 60);
            drive_sequence(pick);
            sent += pick;
        end
    endtask

    // Fills the heap past its depth so that the last pushes are refused.
    // One far segment then pops nearly all entries in a single item.
    task automatic fill_heap();
        womh_cmd_t c;
        write_window(WIN_MAX);
        for (int k = 0; k < FILL_ITEMS; k++)
        begin
            c.begin_req = (k == 0);
            c.seg_end   = 32'sd1000;
            c.seg_start = VAL_W'(1000 - $signed($urandom_range(0, 1_000_000)));
            send_cmd(c, 1'b0, '0);
        end
        c.begin_req = 1'b0;
        c.seg_start = S32_MAX;
        c.seg_end   = S32_MAX;
        send_cmd(c, 1'b0, '0);
    endtask

    // Result checker. A strobe with nothing pending is as much a failure as wrong counts.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_results++;
            if (pending_counts.size() == 0)
                note_mismatch($sformatf("result with nothing pending: live %0d best %0d ovf %0b",
                                        result.live_count, result.best_count,
                                        result.overflow));
            else
            begin
                want = pending_counts.pop_front();
                if (want.overflow)
                    n_refused++;
                if (result.live_count !== want.live_count
                    || result.best_count !== want.best_count
                    || result.overflow !== want.overflow)
                    note_mismatch($sformatf(
                        "result %0d: live %0d/%0d best %0d/%0d ovf %0b/%0b (expected/actual)",
                        n_results, want.live_count, result.live_count,
                        want.best_count, result.best_count,
                        want.overflow, result.overflow));
            end
        end
    end

    initial
    begin
        womh_cmd_t    row_cmd;
        womh_result_t row_res;

        rst_n   = 1'b0;
        start   = 1'b0;
        cmd     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        mirror_fill    = 0;
        mirror_best    = 0;
        mirror_window  = '0;
        idle_pct       = 20;
        mismatch_count = 0;
        n_items        = 0;
        n_results      = 0;
        n_refused      = 0;
        n_win_writes   = 0;
        cycle_count    = 0;

        // Reset is applied once and released on a falling edge.
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table. The first rows rely on the window's reset value of zero.
        for (int i = 0; i < STIM_ROWS; i++)
        begin
            if (STIM_TAB[i].wr)
                write_window(STIM_TAB[i].win);
            row_cmd.begin_req  = STIM_TAB[i].bgn;
            row_cmd.seg_start  = STIM_TAB[i].s;
            row_cmd.seg_end    = STIM_TAB[i].e;
            row_res.live_count = STIM_TAB[i].live;
            row_res.best_count = STIM_TAB[i].best;
            row_res.overflow   = STIM_TAB[i].ovf;
            send_cmd(row_cmd, STIM_TAB[i].chk, row_res);
        end

        // Random part: a sender with occasional gaps, then a sluggish one, then back to back.
        run_phase(20, PHASE_ITEMS);
        run_phase(61, PHASE_ITEMS);
        run_phase(0, PHASE_ITEMS);
        fill_heap();
        write_window('0);
        drive_sequence(20);

        start <= 1'b0;
        while (pending_counts.size() != 0)
            @(negedge clk);
        // Keep the clock running to catch any stray strobe.
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d commands and checked %0d results over %0d window settings.",
                 n_items, n_results, n_win_writes);
        $display("Sender gap rates were 20, 61 and 0 percent; %0d pushes were refused on a full heap.",
                 n_refused);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
